/* rtl/source_token_classifier_assert.svh */
// Assertion macros shared by the classifier RTL
`ifndef SOURCE_TOKEN_CLASSIFIER_ASSERT_SVH
`define SOURCE_TOKEN_CLASSIFIER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define STC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stc assertion failed");

// Next-cycle implication checked outside reset
`define STC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stc assertion failed");

`endif

/* rtl/stc_pkg.sv */
package stc_pkg;

  localparam int unsigned TokenMax    = 32;
  localparam int unsigned DictEntries = 16;
  localparam int unsigned EntryChars  = 16;

  localparam int unsigned TokIdxW = $clog2(TokenMax);
  localparam int unsigned TokLenW = $clog2(TokenMax + 1);
  localparam int unsigned EntIdxW = $clog2(DictEntries);
  localparam int unsigned ChrIdxW = $clog2(EntryChars);
  localparam int unsigned ChrLenW = $clog2(EntryChars + 1);
  localparam int unsigned DictW   = 1 + EntIdxW + ChrIdxW;

  // input actions
  localparam logic [1:0] ActText   = 2'd0;
  localparam logic [1:0] ActWrite  = 2'd1;
  localparam logic [1:0] ActFlush  = 2'd2;
  localparam logic [1:0] ActIgnore = 2'd3;

  // output classes
  localparam logic [1:0] ClsKeyword  = 2'd0;
  localparam logic [1:0] ClsDatatype = 2'd1;
  localparam logic [1:0] ClsComment  = 2'd2;
  localparam logic [1:0] ClsNormal   = 2'd3;

  // comment modes
  localparam logic [1:0] CmNone  = 2'd0;
  localparam logic [1:0] CmLine  = 2'd1;
  localparam logic [1:0] CmBlock = 2'd2;

  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  // front-to-back command queued between the two halves
  typedef struct packed {
    logic [1:0]   action;
    logic [7:0]   byte_value;
    logic         dict_kind;
    logic [3:0]   dict_entry;
    logic [3:0]   dict_pos;
    logic         close_tok;   // this byte or flush closes the token
  } cmd_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

endpackage

/* rtl/stc_front.sv */
// Accepts input transactions, classifies them and pushes commands into a 2-deep queue.
module stc_front import stc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  byte_i,
  input  logic        kind_i,
  input  logic [3:0]  entry_i,
  input  logic [3:0]  pos_i,
  output logic        c_valid_o,
  input  logic        c_ready_i,
  output cmd_t        cmd_o
);
  `include "source_token_classifier_assert.svh"

  cmd_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_w;
  logic       push, pop;

  // classify the incoming item
  always_comb begin
    cmd_w.action     = action_i;
    cmd_w.byte_value = byte_i;
    cmd_w.dict_kind  = kind_i;
    cmd_w.dict_entry = entry_i;
    cmd_w.dict_pos   = pos_i;
    cmd_w.close_tok  = (action_i == ActFlush) ||
                       (action_i == ActText && (byte_i == ChSpace || byte_i == ChTab ||
                        byte_i == ChCr || byte_i == ChLf));
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign c_valid_o = (cnt_q != 2'd0);
  assign cmd_o     = q_mem[rd_q];
  assign push      = s_valid_i && s_ready_o && (action_i != ActIgnore);
  assign pop       = c_valid_o && c_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= cmd_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `STC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3)
  `STC_ASSERT_IMP(a_ptr_sync, cnt_q == 2'd0 || cnt_q == 2'd2, wr_q == rd_q)
  `STC_ASSERT_NXT(a_full, cnt_q == 2'd2 && !pop, cnt_q == 2'd2)
endmodule

/* rtl/stc_back.sv */
// Executes commands: dictionary writes, token buffering and classified emission.
module stc_back import stc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        c_valid_i,
  output logic        c_ready_o,
  input  cmd_t        cmd_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [7:0]  char_o,
  output logic [1:0]  class_o,
  output logic        last_o
);
  `include "source_token_classifier_assert.svh"

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPos   = 3'd1;  // decide class at position j
  localparam logic [2:0] StCmp   = 3'd2;  // compare one char of entry e
  localparam logic [2:0] StNext  = 3'd3;  // finish entry e
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StFetch = 3'd5;  // dictionary read in flight
  localparam logic [2:0] StClr   = 3'd6;  // zero both dictionaries after reset

  logic [2:0]         st_q;
  logic [7:0]         tok_mem [TokenMax];
  logic [7:0]         kw_mem  [DictEntries*EntryChars];
  logic [7:0]         dt_mem  [DictEntries*EntryChars];
  logic [DictW-2:0]   clr_q;
  logic [7:0]         dch_q;
  logic [TokLenW-1:0] len_q, j_q;
  logic [1:0]         cm_q;
  logic [ChrLenW-1:0] run_q, best_q, k_q;
  logic [1:0]         cls_q;
  logic               kind_q, flush_q, mok_q;
  logic [EntIdxW:0]   e_q;
  logic               ob_q;
  logic [7:0]         char_q;
  logic [1:0]         ocls_q;
  logic               olast_q;

  logic [7:0] c, nx, prv, aft;
  logic       has_nx, emit;
  logic [TokLenW:0] jn;
  logic [DictW-2:0] daddr;

  assign c      = tok_mem[j_q[TokIdxW-1:0]];
  assign has_nx = ({1'b0, j_q} + 1'b1) < {1'b0, len_q};
  assign nx     = has_nx ? tok_mem[TokIdxW'(j_q + 1'b1)] : 8'h00;
  assign daddr  = {e_q[EntIdxW-1:0], k_q[ChrIdxW-1:0]};
  assign jn     = {1'b0, j_q} + {{(TokLenW+1-ChrLenW){1'b0}}, k_q};
  assign prv    = (j_q != '0) ? tok_mem[TokIdxW'(j_q - 1'b1)] : 8'h00;
  assign aft    = (jn < {1'b0, len_q}) ? tok_mem[jn[TokIdxW-1:0]] : 8'h00;
  assign emit   = (st_q == StEmit) && (!ob_q || m_ready_i);

  assign c_ready_o = (st_q == StIdle);
  assign m_valid_o = ob_q;
  assign char_o    = char_q;
  assign class_o   = ocls_q;
  assign last_o    = olast_q;

  // dictionary and token storage
  always_ff @(posedge clk_i) begin
    if (st_q == StClr) begin
      kw_mem[clr_q] <= 8'h00;
      dt_mem[clr_q] <= 8'h00;
    end
    if (c_valid_i && c_ready_o) begin
      if (cmd_i.action == ActWrite && cmd_i.dict_entry < DictEntries &&
          cmd_i.dict_pos < EntryChars) begin
        if (cmd_i.dict_kind)
          dt_mem[{EntIdxW'(cmd_i.dict_entry), ChrIdxW'(cmd_i.dict_pos)}] <= cmd_i.byte_value;
        else
          kw_mem[{EntIdxW'(cmd_i.dict_entry), ChrIdxW'(cmd_i.dict_pos)}] <= cmd_i.byte_value;
      end
      if (cmd_i.action == ActText && len_q < TokenMax)
        tok_mem[len_q[TokIdxW-1:0]] <= cmd_i.byte_value;
    end
  end

  // registered dictionary read at the current entry and character
  always_ff @(posedge clk_i) begin
    dch_q <= kind_q ? dt_mem[daddr] : kw_mem[daddr];
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; len_q <= '0; j_q <= '0;
      cm_q <= CmNone; run_q <= '0; best_q <= '0; k_q <= '0; cls_q <= ClsNormal;
      kind_q <= 1'b0; flush_q <= 1'b0; mok_q <= 1'b0; e_q <= '0; ob_q <= 1'b0;
      char_q <= '0; ocls_q <= '0; olast_q <= 1'b0;
    end else begin
      // output register: load on emit, else drain on acceptance
      if (emit) ob_q <= 1'b1;
      else if (ob_q && m_ready_i) ob_q <= 1'b0;
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) st_q <= StIdle;
        end
        StIdle: begin
          if (c_valid_i && c_ready_o) begin
            if (cmd_i.action == ActText) begin
              if (len_q < TokenMax) len_q <= len_q + 1'b1;
              if (cmd_i.close_tok || len_q >= TokenMax - 1) begin
                st_q <= StPos; j_q <= '0; flush_q <= 1'b0;
              end
            end else if (cmd_i.action == ActFlush) begin
              flush_q <= 1'b1;
              if (len_q != '0) begin
                st_q <= StPos; j_q <= '0;
              end else cm_q <= CmNone;
            end
          end
        end
        StPos: begin
          run_q <= ChrLenW'(1);
          if (cm_q == CmNone && has_nx && c == ChSlash && nx == ChSlash) begin
            cm_q <= CmLine; cls_q <= ClsComment; run_q <= ChrLenW'(2); st_q <= StEmit;
          end else if (cm_q == CmNone && has_nx && c == ChSlash && nx == ChStar) begin
            cm_q <= CmBlock; cls_q <= ClsComment; run_q <= ChrLenW'(2); st_q <= StEmit;
          end else if (cm_q == CmLine && c == ChLf) begin
            cm_q <= CmNone; cls_q <= ClsNormal; st_q <= StEmit;
          end else if (cm_q == CmBlock && has_nx && c == ChStar && nx == ChSlash) begin
            cm_q <= CmNone; cls_q <= ClsComment; run_q <= ChrLenW'(2); st_q <= StEmit;
          end else if (cm_q != CmNone) begin
            cls_q <= ClsComment; st_q <= StEmit;
          end else begin
            kind_q <= 1'b0; e_q <= '0; k_q <= '0; best_q <= '0; mok_q <= 1'b1;
            st_q <= StFetch;
          end
        end
        StFetch: begin
          st_q <= StCmp;
        end
        StCmp: begin
          // one character of the current entry per fetch and compare
          if (k_q == EntryChars || dch_q == 8'h00) begin
            if (k_q == '0) begin
              // empty entry ends the list
              if (best_q != '0) begin
                cls_q <= kind_q ? ClsDatatype : ClsKeyword; run_q <= best_q;
                st_q <= StEmit;
              end else if (!kind_q) begin
                kind_q <= 1'b1; e_q <= '0; mok_q <= 1'b1; st_q <= StFetch;
              end else begin
                cls_q <= ClsNormal; st_q <= StEmit;
              end
            end else st_q <= StNext;
          end else begin
            if (jn >= {1'b0, len_q} || tok_mem[jn[TokIdxW-1:0]] != dch_q) mok_q <= 1'b0;
            k_q <= k_q + 1'b1;
            st_q <= StFetch;
          end
        end
        StNext: begin
          if (mok_q && jn <= {1'b0, len_q} && !is_letter(prv) && !is_letter(aft))
            best_q <= k_q;
          k_q <= '0; mok_q <= 1'b1;
          if (e_q == DictEntries - 1) begin
            if (mok_q && jn <= {1'b0, len_q} && !is_letter(prv) && !is_letter(aft)) begin
              cls_q <= kind_q ? ClsDatatype : ClsKeyword; run_q <= k_q; st_q <= StEmit;
            end else if (best_q != '0) begin
              cls_q <= kind_q ? ClsDatatype : ClsKeyword; run_q <= best_q; st_q <= StEmit;
            end else if (!kind_q) begin
              kind_q <= 1'b1; e_q <= '0; st_q <= StFetch;
            end else begin
              cls_q <= ClsNormal; run_q <= ChrLenW'(1); st_q <= StEmit;
            end
          end else begin
            e_q <= e_q + 1'b1; st_q <= StFetch;
          end
        end
        StEmit: begin
          if (emit) begin
            char_q  <= c;
            ocls_q  <= cls_q;
            olast_q <= ({1'b0, j_q} + 1'b1) == {1'b0, len_q};
            j_q     <= j_q + 1'b1;
            run_q   <= run_q - 1'b1;
            if (({1'b0, j_q} + 1'b1) == {1'b0, len_q}) begin
              st_q <= StIdle; len_q <= '0;
              if (flush_q) cm_q <= CmNone;
            end else if (run_q == ChrLenW'(1)) st_q <= StPos;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  `STC_ASSERT_IMP(a_len_bound, 1'b1, len_q <= TokenMax)
  `STC_ASSERT_IMP(a_cm_range, 1'b1, cm_q != 2'd3)
  `STC_ASSERT_IMP(a_emit_in_tok, st_q == StEmit, j_q < len_q)
  `STC_ASSERT_NXT(a_hold_out, ob_q && !m_ready_i, ob_q && $stable(char_q))
endmodule

/* rtl/source_token_classifier.sv */
// Source token classifier. Text bytes (action 0) gather into a token that closes on
// space, tab, CR, LF or at 32 bytes; the token's bytes then leave on the master side,
// one transaction each, tagged keyword, datatype, comment or normal, tlast on the
// last. Dictionary writes (action 1) and flush (action 2) share the input stream;
// action 3 is dropped. After reset both dictionaries are zeroed, during which no
// command is taken. Emitting a token takes, per position outside comments, a
// decision step plus a dictionary scan with a registered read: a fetch and a compare
// per stored character, then a fetch with the end-of-entry check and a finish step
// for each entry (an empty entry that ends a list has no finish step), over the
// keyword list and, if no keyword matches, the datatype list; comment bytes and
// comment delimiters skip the scan. Then the bytes of the run leave one per cycle
// while the master side accepts. The sequencer takes no command while a token is
// being emitted; the output register holds the last byte without blocking the next
// command. A two-entry command queue separates intake from the sequencer.
module source_token_classifier import stc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // byte_value[7:0], dict_entry[11:8], dict_pos[15:12]
  input  logic [2:0]  s_axis_tuser,  // action[1:0], dict_kind[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // char_out[7:0]
  output logic [1:0]  m_axis_tuser,  // char_class[1:0]
  output logic        m_axis_tlast
);
  logic       c_valid, c_ready;
  cmd_t       cmd;

  stc_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid), .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser[1:0]),  .byte_i (s_axis_tdata[7:0]),
    .kind_i    (s_axis_tuser[2]),    .entry_i (s_axis_tdata[11:8]),
    .pos_i     (s_axis_tdata[15:12]),
    .c_valid_o (c_valid), .c_ready_i (c_ready), .cmd_o (cmd)
  );

  stc_back u_back (
    .clk_i, .rst_ni,
    .c_valid_i (c_valid), .c_ready_o (c_ready), .cmd_i (cmd),
    .m_valid_o (m_axis_tvalid), .m_ready_i (m_axis_tready),
    .char_o (m_axis_tdata), .class_o (m_axis_tuser), .last_o (m_axis_tlast)
  );
endmodule
